### sv/adg_pkg.sv
// adg_pkg: shared types and constants of the adagrad parameter update unit
// used by adg_ctrl, adg_datapath, the top and the testbench; depends on nothing
`default_nettype none
package adg_pkg;

  // field widths fixed by the word format
  localparam int unsigned WordW  = 12;
  localparam int unsigned ElemW  = 8;
  localparam int unsigned ValW   = 32;
  localparam int unsigned AccW   = 48;
  localparam int unsigned RateW  = 20;
  localparam int unsigned ProdW  = RateW + ValW;
  localparam int unsigned DataW  = 104;

  // iteration counts of the shared shift-subtract steps
  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned DivSteps  = ProdW;
  localparam int unsigned CntW      = 6;

  localparam logic [RateW-1:0] RateReset = RateW'(3277);

  // command codes
  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_UPDATE = 1'b1
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADDR,
    ST_READ,
    ST_SQUARE,
    ST_ACCUM,
    ST_SQRT,
    ST_MULT,
    ST_DIV,
    ST_APPLY,
    ST_FINISH
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic addr;
    logic square;
    logic accum;
    logic sqrt_step;
    logic mult;
    logic div_step;
    logic apply;
    logic commit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic invalid;
    logic load;
    logic root_zero;
  } dp_status_t;

endpackage
`default_nettype wire

### sv/adg_ram.sv
// adg_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none
module adg_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

### sv/adg_ctrl.sv
// adg_ctrl: sequencing state machine of the adagrad parameter update unit
// depends on adg_pkg
`default_nettype none
module adg_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output adg_pkg::dp_cmd_t         cmd_o,
  input  wire adg_pkg::dp_status_t status_i
);
  import adg_pkg::*;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  logic            can_commit;

  assign can_commit  = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_ADDR;
      end
      ST_ADDR: begin
        if (status_i.invalid || status_i.load) state_d = ST_FINISH;
        else state_d = ST_READ;
      end
      ST_READ:   state_d = ST_SQUARE;
      ST_SQUARE: state_d = ST_ACCUM;
      ST_ACCUM: begin
        state_d = ST_SQRT;
        cnt_d   = '0;
      end
      ST_SQRT: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(SqrtSteps - 1)) state_d = ST_MULT;
      end
      ST_MULT: begin
        cnt_d = '0;
        if (status_i.root_zero) state_d = ST_APPLY;
        else state_d = ST_DIV;
      end
      ST_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(DivSteps - 1)) state_d = ST_APPLY;
      end
      ST_APPLY: state_d = ST_FINISH;
      ST_FINISH: begin
        if (can_commit) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_ADDR:   cmd_o.addr      = 1'b1;
      ST_SQUARE: cmd_o.square    = 1'b1;
      ST_ACCUM:  cmd_o.accum     = 1'b1;
      ST_SQRT:   cmd_o.sqrt_step = 1'b1;
      ST_MULT:   cmd_o.mult      = 1'b1;
      ST_DIV:    cmd_o.div_step  = 1'b1;
      ST_APPLY:  cmd_o.apply     = 1'b1;
      ST_FINISH: begin
        cmd_o.commit = can_commit;
        if (can_commit) out_valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

### sv/adg_datapath.sv
// adg_datapath: parameter stores, square, root, divide and saturating update
// depends on adg_pkg and adg_ram
`default_nettype none
module adg_datapath #(
  parameter int unsigned WORDS = 4096,
  parameter int unsigned DIM   = 128
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         rate_we_i,
  input  wire logic [adg_pkg::RateW-1:0]    rate_i,
  input  wire logic                         in_cmd_i,
  input  wire logic [adg_pkg::DataW-1:0]    in_data_i,
  output logic      [adg_pkg::DataW-1:0]    out_data_o,
  output logic                              out_sat_o,
  input  wire adg_pkg::dp_cmd_t             cmd_i,
  output adg_pkg::dp_status_t               status_o
);
  import adg_pkg::*;

  localparam int unsigned Row     = DIM + 1;
  localparam int unsigned Entries = WORDS * Row;
  localparam int unsigned AddrW   = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned RamD    = (Entries > 1) ? Entries : 2;

  logic [RateW-1:0] rate_q;
  logic             cmd_q;
  logic [WordW-1:0] word_q;
  logic [ElemW-1:0] elem_q;
  logic [ValW-1:0]  val_q, mag;
  logic [AccW-1:0]  accin_q;
  logic [AddrW-1:0] addr_q;
  logic [ValW-1:0]  w_q;
  logic [AccW-1:0]  acc_q;
  logic             sat_q;
  logic [AccW-1:0]  sq_q;
  logic [2*AccW-1:0] x_q;
  logic [33:0]      srem_q;
  logic [ValW-1:0]  root_q;
  logic [35:0]      s_try, s_trial;
  logic [ProdW-1:0] n_q;
  logic [32:0]      d_try;
  logic [AccW:0]    acc_sum;
  logic [53:0]      w_sum;
  logic [ValW-1:0]  ram_w;
  logic [AccW-1:0]  ram_acc;
  logic             ram_we;
  logic [ValW-1:0]  out_w_q;
  logic [AccW-1:0]  out_acc_q;
  logic [WordW-1:0] out_word_q;
  logic [ElemW-1:0] out_elem_q;
  logic             out_sat_q;

  // range check and magnitude of the gradient
  assign status_o.invalid   = (32'(word_q) >= 32'(WORDS)) || (32'(elem_q) > 32'(DIM));
  assign status_o.load      = (cmd_q == CMD_LOAD);
  assign status_o.root_zero = (root_q == '0);
  assign mag = val_q[ValW-1] ? (~val_q + 1'b1) : val_q;

  // one root bit per step, two radicand bits consumed
  assign s_try   = {srem_q, x_q[2*AccW-1 -: 2]};
  assign s_trial = {2'b00, root_q, 2'b01};
  // one quotient bit per step
  assign d_try   = {srem_q[31:0], n_q[ProdW-1]};
  assign acc_sum = {1'b0, acc_q} + {1'b0, sq_q};
  assign w_sum   = val_q[ValW-1] ? ({{22{w_q[ValW-1]}}, w_q} - {2'b00, n_q})
                                 : ({{22{w_q[ValW-1]}}, w_q} + {2'b00, n_q});
  assign ram_we  = cmd_i.commit && !status_o.invalid;

  adg_ram #(.WIDTH(ValW), .DEPTH(RamD)) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i (w_q),
    .raddr_i (addr_q),
    .rdata_o (ram_w)
  );

  adg_ram #(.WIDTH(AccW), .DEPTH(RamD)) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i (acc_q),
    .raddr_i (addr_q),
    .rdata_o (ram_acc)
  );

  // step size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= RateReset;
    end else if (rate_we_i) begin
      rate_q <= rate_i;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q   <= in_cmd_i;
      word_q  <= in_data_i[11:0];
      elem_q  <= in_data_i[19:12];
      val_q   <= in_data_i[51:20];
      accin_q <= in_data_i[99:52];
    end
    if (cmd_i.addr) begin
      addr_q <= AddrW'(32'(word_q) * 32'(Row) + 32'(elem_q));
      sat_q  <= 1'b0;
      if (status_o.invalid) begin
        w_q   <= '0;
        acc_q <= '0;
      end else begin
        w_q   <= val_q;
        acc_q <= accin_q;
      end
    end
    if (cmd_i.square) begin
      w_q   <= ram_w;
      acc_q <= ram_acc;
      sq_q  <= AccW'((64'(mag) * 64'(mag)) >> 16);
    end
    if (cmd_i.accum) begin
      srem_q <= '0;
      root_q <= '0;
      if (acc_sum[AccW]) begin
        acc_q <= '1;
        sat_q <= 1'b1;
        x_q   <= {{AccW{1'b1}}, 16'h0, 32'h0};
      end else begin
        acc_q <= acc_sum[AccW-1:0];
        x_q   <= {acc_sum[AccW-1:0], 16'h0, 32'h0};
      end
    end
    if (cmd_i.sqrt_step) begin
      x_q <= {x_q[2*AccW-3:0], 2'b00};
      if (s_try >= s_trial) begin
        srem_q <= 34'(s_try - s_trial);
        root_q <= {root_q[ValW-2:0], 1'b1};
      end else begin
        srem_q <= s_try[33:0];
        root_q <= {root_q[ValW-2:0], 1'b0};
      end
    end
    if (cmd_i.mult) begin
      srem_q <= '0;
      n_q    <= (root_q == '0) ? '0 : ProdW'(64'(rate_q) * 64'(mag));
    end
    if (cmd_i.div_step) begin
      if (d_try >= {1'b0, root_q}) begin
        srem_q <= {2'b00, 32'(d_try - {1'b0, root_q})};
        n_q    <= {n_q[ProdW-2:0], 1'b1};
      end else begin
        srem_q <= {2'b00, d_try[31:0]};
        n_q    <= {n_q[ProdW-2:0], 1'b0};
      end
    end
    if (cmd_i.apply) begin
      if ($signed(w_sum) > $signed(54'sh7FFFFFFF)) begin
        w_q   <= 32'h7FFFFFFF;
        sat_q <= 1'b1;
      end else if ($signed(w_sum) < -$signed(54'sh80000000)) begin
        w_q   <= 32'h80000000;
        sat_q <= 1'b1;
      end else begin
        w_q <= w_sum[ValW-1:0];
      end
    end
    // result register
    if (cmd_i.commit) begin
      out_word_q <= word_q;
      out_elem_q <= elem_q;
      out_w_q    <= w_q;
      out_acc_q  <= acc_q;
      out_sat_q  <= sat_q;
    end
  end

  assign out_data_o = {4'h0, out_acc_q, out_w_q, out_elem_q, out_word_q};
  assign out_sat_o  = out_sat_q;

endmodule
`default_nettype wire

### sv/adagrad_parameter_update_unit.sv
// sequence of an update: address, read, square and accumulate, then 32 root steps,
// a multiply, 52 divide steps, apply and commit; the divide is skipped when the root is
// zero, and a load or an out-of-range entry goes from address straight to commit; one
// word at a time, so a new word is taken only after the last one is committed, and it
// may be taken while the previous result still waits on the output
// reset clears control and restores learning_rate to 3277; stores are not cleared
`default_nettype none
module adagrad_parameter_update_unit #(
  parameter int unsigned WORDS = 4096,
  parameter int unsigned DIM   = 128
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          learning_rate_we_i,
  input  wire logic [19:0]   learning_rate_i,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  // word[11:0], element[19:12], value[51:20], accumulator_value[99:52]
  input  wire logic [103:0]  s_axis_tdata,
  // command[0]
  input  wire logic          s_axis_tuser,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  // word_out[11:0], element_out[19:12], new_weight[51:20], new_accumulator[99:52]
  output logic [103:0]       m_axis_tdata,
  // saturated[0]
  output logic               m_axis_tuser
);
  import adg_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  adg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  adg_datapath #(.WORDS(WORDS), .DIM(DIM)) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rate_we_i  (learning_rate_we_i),
    .rate_i     (learning_rate_i),
    .in_cmd_i   (s_axis_tuser),
    .in_data_i  (s_axis_tdata),
    .out_data_o (m_axis_tdata),
    .out_sat_o  (m_axis_tuser),
    .cmd_i      (cmd),
    .status_o   (status)
  );

endmodule
`default_nettype wire

### sv/adg_checker.sv
// adg_checker: port-level checks of the adagrad parameter update unit
// bound to adagrad_parameter_update_unit; depends on nothing else
`default_nettype none
module adg_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [103:0] m_axis_tdata,
  input wire logic         m_axis_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // one word at a time
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second word taken while busy");

  // no result appears right after an accept
  a_no_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result too early");

endmodule

bind adagrad_parameter_update_unit adg_checker u_adg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

### dv/adagrad_parameter_update_unit_tb.sv
// adagrad_parameter_update_unit_tb: self-checking testbench of the adagrad update unit
// drives load and update words on the input stream and checks every output word
// against an in-bench predictor; depends on adg_pkg and adagrad_parameter_update_unit
`timescale 1ns / 1ps
`default_nettype none
module adagrad_parameter_update_unit_tb;
  import adg_pkg::*;

  localparam int unsigned NumWords = 4096;
  localparam int unsigned NumDim   = 128;
  localparam longint unsigned AccMax = 64'hFFFF_FFFF_FFFF;
  localparam int CycleLimit = 1000000;
  localparam int DrainCycles = 200;

  typedef struct {
    logic [WordW-1:0] word;
    logic [ElemW-1:0] elem;
    logic [ValW-1:0]  weight;
    logic [AccW-1:0]  acc;
    logic             sat;
  } entry_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              learning_rate_we_i = 1'b0;
  logic [RateW-1:0]  learning_rate_i = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [DataW-1:0]  s_axis_tdata = '0;
  logic              s_axis_tuser = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [DataW-1:0]  m_axis_tdata;
  logic              m_axis_tuser;

  // predictor state
  logic [ValW-1:0]   weight_mem [int];
  logic [AccW-1:0]   accum_mem [int];
  logic [RateW-1:0]  rate_q = RateReset;
  int                loaded_q[$];
  entry_t            pending_q[$];
  int                err_cnt = 0;
  int                cycle_cnt = 0;
  bit                idle_en = 1'b1;

  adagrad_parameter_update_unit #(
    .WORDS(NumWords),
    .DIM  (NumDim)
  ) i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .learning_rate_we_i(learning_rate_we_i),
    .learning_rate_i   (learning_rate_i),
    .s_axis_tvalid     (s_axis_tvalid),
    .s_axis_tready     (s_axis_tready),
    .s_axis_tdata      (s_axis_tdata),
    .s_axis_tuser      (s_axis_tuser),
    .m_axis_tvalid     (m_axis_tvalid),
    .m_axis_tready     (m_axis_tready),
    .m_axis_tdata      (m_axis_tdata),
    .m_axis_tuser      (m_axis_tuser)
  );

  always #6 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("%0t timeout", $time);
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // expected entry after one command, store updated as a side effect
  function automatic entry_t adagrad_predict(cmd_e cmd, logic [WordW-1:0] word,
                                             logic [ElemW-1:0] elem, logic [ValW-1:0] val,
                                             logic [AccW-1:0] acc_in);
    entry_t e;
    int addr;
    longint g;
    longint w;
    longint unsigned mag;
    longint unsigned acc;
    longint unsigned root;
    longint unsigned q;
    e.word = word;
    e.elem = elem;
    e.weight = '0;
    e.acc = '0;
    e.sat = 1'b0;
    if (word >= NumWords || elem > NumDim) return e;
    addr = int'(word) * (NumDim + 1) + int'(elem);
    g = longint'($signed(val));
    if (cmd == CMD_LOAD) begin
      w = g;
      acc = acc_in;
    end else begin
      mag = (g < 0) ? longint'(-g) : g;
      w = longint'($signed(weight_mem[addr]));
      acc = longint'(accum_mem[addr]) + ((mag * mag) >> 16);
      if (acc > AccMax) begin
        acc = AccMax;
        e.sat = 1'b1;
      end
      root = int_sqrt(acc << 16);
      // a zero root leaves the weight alone
      if (root != 0) begin
        q = (longint'(rate_q) * mag) / root;
        w = (g < 0) ? w - longint'(q) : w + longint'(q);
        if (w > 64'sd2147483647) begin
          w = 64'sd2147483647;
          e.sat = 1'b1;
        end else if (w < -64'sd2147483648) begin
          w = -64'sd2147483648;
          e.sat = 1'b1;
        end
      end
    end
    weight_mem[addr] = w[ValW-1:0];
    accum_mem[addr] = acc[AccW-1:0];
    e.weight = w[ValW-1:0];
    e.acc = acc[AccW-1:0];
    return e;
  endfunction

  // send one word, hold until accepted, then record its expectation
  task automatic send_word(cmd_e cmd, logic [WordW-1:0] word, logic [ElemW-1:0] elem,
                           logic [ValW-1:0] val, logic [AccW-1:0] acc_in);
    int addr;
    if (idle_en) begin
      while ($urandom_range(99) < 22) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {4'b0, acc_in, val, elem, word};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_q.insert(pending_q.size(), adagrad_predict(cmd, word, elem, val, acc_in));
    if (cmd == CMD_LOAD && word < NumWords && elem <= NumDim) begin
      addr = int'(word) * (NumDim + 1) + int'(elem);
      if (!(addr inside {loaded_q})) loaded_q.insert(loaded_q.size(), addr);
    end
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_rate(logic [RateW-1:0] rate);
    wait_idle();
    learning_rate_we_i <= 1'b1;
    learning_rate_i    <= rate;
    @(posedge clk_i);
    learning_rate_we_i <= 1'b0;
    rate_q = rate;
  endtask

  // update of an entry that some load already wrote
  task automatic update_loaded(logic [ValW-1:0] grad);
    int addr;
    addr = loaded_q[$urandom_range(loaded_q.size() - 1)];
    send_word(CMD_UPDATE, WordW'(addr / (NumDim + 1)), ElemW'(addr % (NumDim + 1)), grad, '0);
  endtask

  function automatic logic [ValW-1:0] rand_grad();
    case ($urandom_range(3))
      0:       return $urandom();
      1:       return ValW'($signed($urandom_range(131072)) - 65536);
      2:       return {{16{$urandom_range(1) == 1}}, 16'($urandom())};
      default: return ValW'($signed($urandom_range(16777216)) - 8388608);
    endcase
  endfunction

  function automatic logic [AccW-1:0] rand_acc();
    case ($urandom_range(2))
      0:       return {16'($urandom()), 32'($urandom())};
      1:       return AccW'($urandom_range(1 << 20));
      default: return '0;
    endcase
  endfunction

  // output side: random stall and compare with the oldest expectation
  always @(posedge clk_i) begin
    entry_t exp_e;
    m_axis_tready <= !idle_en || ($urandom_range(99) >= 22);
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_q.size() == 0) begin
        $display("%0t unexpected word: actual %h/%b", $time, m_axis_tdata, m_axis_tuser);
        err_cnt++;
      end else begin
        exp_e = pending_q.pop_front();
        if (m_axis_tdata[11:0] !== exp_e.word) begin
          $display("%0t word_out: expected %h actual %h", $time, exp_e.word,
                   m_axis_tdata[11:0]);
          err_cnt++;
        end
        if (m_axis_tdata[19:12] !== exp_e.elem) begin
          $display("%0t element_out: expected %h actual %h", $time, exp_e.elem,
                   m_axis_tdata[19:12]);
          err_cnt++;
        end
        if (m_axis_tdata[51:20] !== exp_e.weight) begin
          $display("%0t new_weight: expected %h actual %h", $time, exp_e.weight,
                   m_axis_tdata[51:20]);
          err_cnt++;
        end
        if (m_axis_tdata[99:52] !== exp_e.acc) begin
          $display("%0t new_accumulator: expected %h actual %h", $time, exp_e.acc,
                   m_axis_tdata[99:52]);
          err_cnt++;
        end
        if (m_axis_tuser !== exp_e.sat) begin
          $display("%0t saturated: expected %b actual %b", $time, exp_e.sat, m_axis_tuser);
          err_cnt++;
        end
      end
    end
  end

  // field extremes, out-of-range elements and saturation
  task automatic test_directed();
    send_word(CMD_LOAD, 12'd0, 8'd0, 32'h8000_0000, '0);
    send_word(CMD_UPDATE, 12'd0, 8'd0, 32'h0, '0);
    send_word(CMD_UPDATE, 12'd0, 8'd0, 32'h8000_0000, '0);
    send_word(CMD_LOAD, 12'hFFF, 8'd128, 32'h7FFF_FFFF, 48'hFFFF_FFFF_FFFF);
    send_word(CMD_UPDATE, 12'hFFF, 8'd128, 32'h7FFF_FFFF, '0);
    send_word(CMD_UPDATE, 12'hFFF, 8'd128, 32'h0, '0);
    send_word(CMD_LOAD, 12'd5, 8'd7, 32'h7FFF_0000, 48'd1);
    send_word(CMD_UPDATE, 12'd5, 8'd7, 32'h0001_0000, '0);
    send_word(CMD_UPDATE, 12'd5, 8'd7, 32'hFFFF_0000, '0);
    send_word(CMD_LOAD, 12'd5, 8'd8, 32'h8000_0100, 48'd0);
    send_word(CMD_UPDATE, 12'd5, 8'd8, 32'hFFFF_FFFF, '0);
    send_word(CMD_UPDATE, 12'd5, 8'd8, 32'h8000_0000, '0);
    send_word(CMD_LOAD, 12'd9, 8'd129, 32'h1234_5678, 48'hABCD);
    send_word(CMD_UPDATE, 12'd9, 8'd255, 32'hFFFF_FFFF, '0);
    send_word(CMD_LOAD, 12'hAAA, 8'hFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    send_word(CMD_UPDATE, 12'h555, 8'd200, 32'h5555_5555, 48'h5555_5555_5555);
    send_word(CMD_LOAD, 12'h555, 8'd64, 32'h0, 48'h8000_0000_0000);
    send_word(CMD_UPDATE, 12'h555, 8'd64, 32'h0100_0000, '0);
  endtask

  // register extremes: zero and full-scale step size
  task automatic test_rate_extremes();
    write_rate('0);
    send_word(CMD_UPDATE, 12'd0, 8'd0, 32'h4000_0000, '0);
    update_loaded(32'h0002_0000);
    write_rate({RateW{1'b1}});
    send_word(CMD_LOAD, 12'd1, 8'd1, 32'h0, 48'd0);
    send_word(CMD_UPDATE, 12'd1, 8'd1, 32'h0000_0001, '0);
    send_word(CMD_UPDATE, 12'd1, 8'd1, 32'hFFFF_FFFF, '0);
    update_loaded(32'h8000_0000);
  endtask

  // mostly updates on loaded entries, some loads, some out-of-range elements
  task automatic test_random(int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      if (i == count / 3) idle_en = 1'b0;
      if (i == count / 3 + 150) idle_en = 1'b1;
      if (i == count / 2) wait_idle();
      if (i == (2 * count) / 3) write_rate(RateW'($urandom()));
      pick = $urandom_range(99);
      if (pick < 12 || loaded_q.size() == 0)
        send_word(CMD_LOAD, WordW'($urandom()), ElemW'($urandom_range(NumDim)),
                  rand_grad(), rand_acc());
      else if (pick < 17)
        send_word(cmd_e'($urandom_range(1)), WordW'($urandom()),
                  ElemW'($urandom_range(255, NumDim + 1)), $urandom(), rand_acc());
      else
        update_loaded(rand_grad());
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_rate_extremes();
    write_rate(RateReset);
    test_random(920);
    wait_idle();
    if (err_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire

### filelist.f
sv/adg_pkg.sv
sv/adg_ram.sv
sv/adg_ctrl.sv
sv/adg_datapath.sv
sv/adagrad_parameter_update_unit.sv
sv/adg_checker.sv
dv/adagrad_parameter_update_unit_tb.sv
